// ===== rtl/salcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package salcp_pkg;
   localparam int MaxLenDefault = 64;
   localparam int PosWidth = 6;
   localparam int SymWidth = 8;
endpackage
`default_nettype wire

// ===== rtl/suffix_array_lcp_builder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load: one byte per cycle, back to back, no result until the final byte.
// After the final byte the block sorts by insertion with a byte-serial suffix
// compare, one text byte pair at a time through S_CMPA, S_CMPB and S_CMPC.
// The rank pass reads sa[r] then writes rank, the Kasai pass compares byte by byte
// from the carried height, and output reads sa and lcp per rank; rsp holds under stall.
// Synchronous reset returns the sequencer to load with an empty string.
module suffix_array_lcp_builder_top #(
   parameter int MaxLen = salcp_pkg::MaxLenDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_final_symbol,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [5:0]      rsp_sorted_index,
   output logic [5:0]      rsp_suffix_start,
   output logic [5:0]      rsp_common_prefix_len,
   output logic            rsp_truncated,
   output logic            rsp_last_result
);
   localparam int AW = $clog2(MaxLen);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] MaxCnt = CW'(MaxLen);

   typedef enum logic [13:0] {
      S_LOAD   = 14'b00000000000001,
      S_INS    = 14'b00000000000010, // start insertion of suffix i
      S_RDJ    = 14'b00000000000100, // read sa[j-1]
      S_CMPA   = 14'b00000000001000, // issue text[a]
      S_CMPB   = 14'b00000000010000, // issue text[b], capture a
      S_CMPC   = 14'b00000000100000, // compare bytes
      S_SHIFT  = 14'b00000001000000,
      S_PLACE  = 14'b00000010000000,
      S_RANK   = 14'b00000100000000,
      S_KRK    = 14'b00001000000000,
      S_KPREV  = 14'b00010000000000,
      S_KCMP   = 14'b00100000000000,
      S_ORD    = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] len_ff, len_in, i_ff, i_in, j_ff, j_in, h_ff, h_in;
   logic [CW-1:0] a_ff, a_in, b_ff, b_in;
   logic [AW-1:0] p_ff, p_in, prev_ff, prev_in;
   logic [7:0]    ta_ff, ta_in;
   logic          ovf_ff, ovf_in, phase_ff, phase_in;
   logic          out_v_ff, out_v_in;
   logic [5:0]    o_idx_ff, o_idx_in, o_st_ff, o_st_in, o_lcp_ff, o_lcp_in;
   logic          o_tr_ff, o_tr_in, o_last_ff, o_last_in;

   // Memory ports.
   logic          t_we, s_we, r_we, l_we;
   logic [AW-1:0] t_wa, t_ra, s_wa, s_ra, r_wa, r_ra, l_wa, l_ra;
   logic [7:0]    t_wd, t_rd;
   logic [AW-1:0] s_wd, s_rd, r_wd, r_rd;
   logic [5:0]    l_wd, l_rd;

   salcp_ram #(.Width(8),  .Depth(MaxLen)) u_text (.clock(clock), .wr_en(t_we),
      .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   salcp_ram #(.Width(AW), .Depth(MaxLen)) u_sa (.clock(clock), .wr_en(s_we),
      .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));
   salcp_ram #(.Width(AW), .Depth(MaxLen)) u_rank (.clock(clock), .wr_en(r_we),
      .wr_addr(r_wa), .wr_data(r_wd), .rd_addr(r_ra), .rd_data(r_rd));
   salcp_ram #(.Width(6),  .Depth(MaxLen)) u_lcp (.clock(clock), .wr_en(l_we),
      .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra), .rd_data(l_rd));

   logic req_acc, out_free;
   assign req_stall = (state_ff != S_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !out_v_ff || !rsp_stall;

   // Sequencer with a shared text read port and byte register.
   always_comb begin
      state_in = state_ff; len_in = len_ff; i_in = i_ff; j_in = j_ff; h_in = h_ff;
      a_in = a_ff; b_in = b_ff; p_in = p_ff; prev_in = prev_ff; ta_in = ta_ff;
      ovf_in = ovf_ff; phase_in = phase_ff;
      out_v_in = out_v_ff && rsp_stall;
      o_idx_in = o_idx_ff; o_st_in = o_st_ff; o_lcp_in = o_lcp_ff;
      o_tr_in = o_tr_ff; o_last_in = o_last_ff;
      t_we = 1'b0; t_wa = len_ff[AW-1:0]; t_wd = req_symbol; t_ra = a_ff[AW-1:0];
      s_we = 1'b0; s_wa = j_ff[AW-1:0]; s_wd = p_ff; s_ra = '0;
      r_we = 1'b0; r_wa = s_rd; r_wd = '0; r_ra = i_ff[AW-1:0];
      l_we = 1'b0; l_wa = '0; l_wd = 6'(h_ff); l_ra = i_ff[AW-1:0];
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (len_ff < MaxCnt) begin
                  t_we = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_final_symbol) begin
                  i_in = '0;
                  state_in = S_INS;
               end
            end
         end
         S_INS: begin
            if (i_ff == len_ff) begin
               i_in = '0; phase_in = 1'b0;
               state_in = S_RANK;
            end else begin
               j_in = i_ff;
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            // Fetch sorted entry j-1 for comparison.
            s_ra = AW'(j_ff - 1'b1);
            if (j_ff == '0) state_in = S_PLACE;
            else begin
               phase_in = 1'b0;
               state_in = S_CMPA;
            end
         end
         S_CMPA: begin
            if (!phase_ff) begin
               p_in = s_rd;
               a_in = i_ff; b_in = CW'(s_rd);
               phase_in = 1'b1;
               state_in = S_CMPA;
            end else if (a_ff >= len_ff || b_ff >= len_ff) begin
               // Prefix rule: i less only if it ran out first.
               if (a_ff >= len_ff && b_ff < len_ff) state_in = S_SHIFT;
               else state_in = S_PLACE;
            end else begin
               t_ra = a_ff[AW-1:0];
               state_in = S_CMPB;
            end
         end
         S_CMPB: begin
            t_ra = b_ff[AW-1:0];
            ta_in = t_rd;
            state_in = S_CMPC;
         end
         S_CMPC: begin
            if (ta_ff != t_rd) state_in = (ta_ff < t_rd) ? S_SHIFT : S_PLACE;
            else begin
               a_in = a_ff + 1'b1; b_in = b_ff + 1'b1;
               state_in = S_CMPA;
            end
         end
         S_SHIFT: begin
            s_we = 1'b1; s_wa = j_ff[AW-1:0]; s_wd = p_ff;
            j_in = j_ff - 1'b1;
            state_in = S_RDJ;
         end
         S_PLACE: begin
            s_we = 1'b1; s_wa = j_ff[AW-1:0]; s_wd = i_ff[AW-1:0];
            i_in = i_ff + 1'b1;
            state_in = S_INS;
         end
         S_RANK: begin
            // Per rank: read sa[r], then write rank.
            s_ra = i_ff[AW-1:0];
            if (!phase_ff) phase_in = 1'b1;
            else begin
               r_we = 1'b1; r_wa = s_rd; r_wd = i_ff[AW-1:0];
               phase_in = 1'b0;
               if (i_ff + 1'b1 == len_ff) begin
                  i_in = '0; h_in = '0;
                  l_we = 1'b1; l_wa = '0; l_wd = '0;
                  state_in = S_KRK;
               end else i_in = i_ff + 1'b1;
            end
         end
         S_KRK: begin
            // Read rank[i], then sa[rank-1].
            r_ra = i_ff[AW-1:0];
            if (i_ff == len_ff) begin
               i_in = '0; phase_in = 1'b0;
               state_in = S_ORD;
            end else if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               if (r_rd == '0) begin
                  h_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  prev_in = r_rd;
                  s_ra = AW'(r_rd - 1'b1);
                  state_in = S_KPREV;
               end
            end
         end
         S_KPREV: begin
            if (!phase_ff) begin
               p_in = s_rd;
               a_in = i_ff + h_ff; b_in = CW'(s_rd) + h_ff;
               phase_in = 1'b1;
            end else if (a_ff >= len_ff || b_ff >= len_ff) begin
               l_we = 1'b1; l_wa = prev_ff; l_wd = 6'(h_ff);
               h_in = (h_ff != '0) ? h_ff - 1'b1 : h_ff;
               i_in = i_ff + 1'b1; phase_in = 1'b0;
               state_in = S_KRK;
            end else begin
               t_ra = a_ff[AW-1:0];
               state_in = S_KCMP;
               phase_in = 1'b0;
            end
         end
         S_KCMP: begin
            t_ra = b_ff[AW-1:0];
            if (!phase_ff) begin
               ta_in = t_rd; phase_in = 1'b1;
            end else if (ta_ff == t_rd) begin
               h_in = h_ff + 1'b1; a_in = a_ff + 1'b1; b_in = b_ff + 1'b1;
               state_in = S_KPREV;
            end else begin
               l_we = 1'b1; l_wa = prev_ff; l_wd = 6'(h_ff);
               h_in = (h_ff != '0) ? h_ff - 1'b1 : h_ff;
               i_in = i_ff + 1'b1; phase_in = 1'b0;
               state_in = S_KRK;
            end
         end
         S_ORD: begin
            s_ra = i_ff[AW-1:0]; l_ra = i_ff[AW-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            s_ra = i_ff[AW-1:0]; l_ra = i_ff[AW-1:0];
            if (out_free) begin
               out_v_in = 1'b1;
               o_idx_in = 6'(i_ff); o_st_in = 6'(s_rd);
               o_lcp_in = (i_ff == '0) ? 6'd0 : l_rd;
               o_tr_in = ovf_ff; o_last_in = (i_ff + 1'b1 == len_ff);
               if (i_ff + 1'b1 == len_ff) begin
                  len_in = '0; ovf_in = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  i_in = i_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; len_ff <= '0; ovf_ff <= 1'b0; out_v_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in; len_ff <= len_in; ovf_ff <= ovf_in;
         out_v_ff <= out_v_in; phase_ff <= phase_in;
      end
      i_ff <= i_in; j_ff <= j_in; h_ff <= h_in; a_ff <= a_in; b_ff <= b_in;
      p_ff <= p_in; prev_ff <= prev_in; ta_ff <= ta_in;
      o_idx_ff <= o_idx_in; o_st_ff <= o_st_in; o_lcp_ff <= o_lcp_in;
      o_tr_ff <= o_tr_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_sorted_index = o_idx_ff;
   assign rsp_suffix_start = o_st_ff;
   assign rsp_common_prefix_len = o_lcp_ff;
   assign rsp_truncated = o_tr_ff;
   assign rsp_last_result = o_last_ff;

`ifndef NO_ASSERTIONS
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MaxCnt) else $error("length over capacity");
   a_rank0_lcp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sorted_index == 6'd0 |-> rsp_common_prefix_len == 6'd0)
      else $error("rank zero prefix nonzero");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> len_ff != '0 || !ovf_ff)
      else $error("overflow with empty string");
`endif
endmodule
`default_nettype wire

// ===== rtl/salcp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module salcp_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
